@@ rtl/sjf_pkg.sv @@
// shared types, constants and address helper for the shortest-job-first ready queue
`default_nettype none

package sjf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int BURST_BITS  = 16;
    localparam int ADDR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS    = ADDR_BITS + 1;
    localparam int ENTRY_BITS  = ID_BITS + BURST_BITS;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    localparam logic [1:0] RSN_TICK  = 2'd0;
    localparam logic [1:0] RSN_BLOCK = 2'd1;
    localparam logic [1:0] RSN_EXIT  = 2'd2;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [BURST_BITS-1:0] burst;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_PLACE = 4'b0100,
        ST_EVT   = 4'b1000
    } t_state;

    // physical slot of a logical queue position in the circular buffer
    function automatic logic [ADDR_BITS-1:0] phys_addr(input logic [ADDR_BITS-1:0] head,
                                                       input logic [CNT_BITS-1:0]  pos);
        logic [CNT_BITS-1:0] sum;
        sum = CNT_BITS'(head) + pos;
        if (sum >= CNT_BITS'(QUEUE_DEPTH)) begin
            sum = sum - CNT_BITS'(QUEUE_DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/sjf_ram.sv @@
// simple dual-port ram with registered read data
`default_nettype none

module sjf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/shortest_job_first_scheduler_core.sv @@
// top level: sorted ready queue sequencer around a circular-buffer ram
// load: written straight to the head when the queue is empty, dropped when it is full; otherwise
//   one ram read and compare per cycle while walking back from the tail, shifting each larger entry
//   one slot toward the tail, then one write to place the new task behind any equal burst or at the head
// one input transaction at a time; loads are taken while a result waits at the output
// synchronous active-low reset empties the queue; no clearing pass over the ram
`default_nettype none

module shortest_job_first_scheduler_core
    import sjf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_kind,
    input  wire logic [ID_BITS-1:0]    i_task_id,
    input  wire logic [BURST_BITS-1:0] i_burst,
    input  wire logic [1:0]            i_reason,
    input  wire logic [ID_BITS-1:0]    i_current_task,
    input  wire logic                  i_current_idle,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [ID_BITS-1:0]    o_next_task,
    output logic                       o_next_idle
);

    t_state                r_state,   n_state;
    logic [CNT_BITS-1:0]   r_count,   n_count;
    logic [ADDR_BITS-1:0]  r_head,    n_head;
    logic [CNT_BITS-1:0]   r_pos,     n_pos;
    t_entry                r_new,     n_new;
    logic [1:0]            r_reason,  n_reason;
    logic [ID_BITS-1:0]    r_cur,     n_cur;
    logic                  r_cur_idle, n_cur_idle;
    logic                  r_out_valid, n_out_valid;
    logic [ID_BITS-1:0]    r_out_task, n_out_task;
    logic                  r_out_idle, n_out_idle;

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    t_entry                ram_wdata;
    logic                  ram_re;
    logic [ADDR_BITS-1:0]  ram_raddr;
    t_entry                ram_rdata;
    logic [ENTRY_BITS-1:0] ram_rdata_bits;

    logic                  in_fire;
    logic                  out_free;
    logic                  do_pop;

    sjf_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );

    assign ram_rdata   = t_entry'(ram_rdata_bits);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign do_pop      = (r_count != '0) &&
                         ((r_reason == RSN_EXIT) || ((r_reason == RSN_TICK) && r_cur_idle));
    assign o_out_valid = r_out_valid;
    assign o_next_task = r_out_task;
    assign o_next_idle = r_out_idle;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_pos       = r_pos;
        n_new       = r_new;
        n_reason    = r_reason;
        n_cur       = r_cur;
        n_cur_idle  = r_cur_idle;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_task  = r_out_task;
        n_out_idle  = r_out_idle;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = r_new;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_kind == KIND_LOAD) begin
                        n_new.id    = i_task_id;
                        n_new.burst = i_burst;
                        if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = phys_addr(r_head, '0);
                            ram_wdata = n_new;
                            n_count   = CNT_BITS'(1);
                        end else if (r_count != CNT_BITS'(QUEUE_DEPTH)) begin
                            // walk back from the tail
                            ram_re    = 1'b1;
                            ram_raddr = phys_addr(r_head, r_count - CNT_BITS'(1));
                            n_pos     = r_count;
                            n_state   = ST_SCAN;
                        end
                    end else begin
                        n_reason   = i_reason;
                        n_cur      = i_current_task;
                        n_cur_idle = i_current_idle;
                        ram_re     = 1'b1;
                        ram_raddr  = phys_addr(r_head, '0);
                        n_state    = ST_EVT;
                    end
                end
            end
            ST_SCAN: begin
                ram_we    = 1'b1;
                ram_waddr = phys_addr(r_head, r_pos);
                if (ram_rdata.burst > r_new.burst) begin
                    // move the larger entry one slot toward the tail
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos - CNT_BITS'(1);
                    if (r_pos == CNT_BITS'(1)) begin
                        n_state = ST_PLACE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = phys_addr(r_head, r_pos - CNT_BITS'(2));
                    end
                end else begin
                    ram_wdata = r_new;
                    n_count   = r_count + CNT_BITS'(1);
                    n_state   = ST_IDLE;
                end
            end
            ST_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = phys_addr(r_head, '0);
                ram_wdata = r_new;
                n_count   = r_count + CNT_BITS'(1);
                n_state   = ST_IDLE;
            end
            ST_EVT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (do_pop) begin
                        n_out_task = ram_rdata.id;
                        n_out_idle = 1'b0;
                        n_count    = r_count - CNT_BITS'(1);
                        n_head     = (r_head == ADDR_BITS'(QUEUE_DEPTH - 1)) ?
                                     '0 : r_head + ADDR_BITS'(1);
                    end else if ((r_reason == RSN_EXIT) || r_cur_idle) begin
                        n_out_task = '0;
                        n_out_idle = 1'b1;
                    end else begin
                        n_out_task = r_cur;
                        n_out_idle = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_new      <= n_new;
        r_reason   <= n_reason;
        r_cur      <= n_cur;
        r_cur_idle <= n_cur_idle;
        r_out_task <= n_out_task;
        r_out_idle <= n_out_idle;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_scan_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_pos != '0) && (r_pos <= r_count))
        else $error("scan position out of range");

    a_ram_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("ram read and write to the same slot");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CNT_BITS'(1)) ||
             (r_count == $past(r_count) - CNT_BITS'(1))))
        else $error("queue count moved by more than one");

    a_result_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EVT) && out_free) |=> o_out_valid && (r_state == ST_IDLE))
        else $error("event finished without a result");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the shortest-job-first ready queue core
`timescale 1ns / 1ps

module tb_top;
    import sjf_pkg::*;

    localparam int N_RANDOM      = 2000;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
    localparam logic [1:0] RSN_RESERVED = 2'd3;

    typedef struct {
        logic                  kind;
        logic [ID_BITS-1:0]    task_id;
        logic [BURST_BITS-1:0] burst;
        logic [1:0]            reason;
        logic [ID_BITS-1:0]    current_task;
        logic                  current_idle;
        bit                    drain_first;
    } t_item;

    typedef struct {
        logic [ID_BITS-1:0] next_task;
        logic               next_idle;
    } t_choice;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind         = KIND_LOAD;
    logic [ID_BITS-1:0]    i_task_id      = '0;
    logic [BURST_BITS-1:0] i_burst        = '0;
    logic [1:0]            i_reason       = RSN_TICK;
    logic [ID_BITS-1:0]    i_current_task = '0;
    logic                  i_current_idle = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [ID_BITS-1:0]    o_next_task;
    logic                  o_next_idle;

    t_item   pending_items[$];
    t_item   offered;
    t_entry  ready_tasks[$];
    t_choice next_task_expected[$];

    int n_items_total = 0;
    int n_accepted    = 0;
    int n_loads       = 0;
    int n_dropped     = 0;
    int n_events      = 0;
    int n_popped      = 0;
    int n_checked     = 0;
    int n_errors      = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    int hold_count    = 0;
    int hold_at[2]    = '{60, 1300};

    shortest_job_first_scheduler_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_task_id      (i_task_id),
        .i_burst        (i_burst),
        .i_reason       (i_reason),
        .i_current_task (i_current_task),
        .i_current_idle (i_current_idle),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_next_task    (o_next_task),
        .o_next_idle    (o_next_idle)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_item make_load(input logic [ID_BITS-1:0]    id,
                                        input logic [BURST_BITS-1:0] burst);
        t_item it;
        it.kind         = KIND_LOAD;
        it.task_id      = id;
        it.burst        = burst;
        it.reason       = 2'($urandom_range(3));
        it.current_task = ID_BITS'($urandom);
        it.current_idle = 1'($urandom_range(1));
        it.drain_first  = 1'b0;
        return it;
    endfunction

    function automatic t_item make_event(input logic [1:0]         reason,
                                         input logic [ID_BITS-1:0] cur,
                                         input logic               cur_idle);
        t_item it;
        it.kind         = KIND_EVENT;
        it.task_id      = ID_BITS'($urandom);
        it.burst        = BURST_BITS'($urandom);
        it.reason       = reason;
        it.current_task = cur;
        it.current_idle = cur_idle;
        it.drain_first  = 1'b0;
        return it;
    endfunction

    function automatic void add_item(input t_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // stable sorted insert on load, head pop on exit or idle tick
    function automatic void predict_next_task(input t_item it);
        t_entry  e;
        t_choice c;
        int      pos;
        if (it.kind == KIND_LOAD) begin
            n_loads++;
            if (ready_tasks.size() >= QUEUE_DEPTH) begin
                n_dropped++;
                return;
            end
            e.id    = it.task_id;
            e.burst = it.burst;
            pos     = 0;
            while (pos < ready_tasks.size() && ready_tasks[pos].burst <= it.burst) pos++;
            ready_tasks.insert(pos, e);
            return;
        end
        n_events++;
        c.next_idle = it.current_idle;
        c.next_task = it.current_idle ? '0 : it.current_task;
        if ((it.reason == RSN_EXIT || (it.reason == RSN_TICK && it.current_idle))
            && ready_tasks.size() > 0) begin
            e           = ready_tasks.pop_front();
            c.next_task = e.id;
            c.next_idle = 1'b0;
            n_popped++;
        end else if (it.reason == RSN_EXIT) begin
            c.next_task = '0;
            c.next_idle = 1'b1;
        end
        next_task_expected.insert(next_task_expected.size(), c);
    endfunction

    function automatic int idle_pct(input bit receiver);
        int third;
        third = n_items_total / 3;
        if (n_accepted < third) return receiver ? 69 : 6;
        if (n_accepted < 2 * third) return receiver ? 6 : 69;
        return 0;
    endfunction

    task automatic flag_mismatch(input string what, input t_choice want);
        n_errors++;
        if (n_errors <= 10) begin
            $display("%s: expected task %0d idle %0b, got task %0d idle %0b",
                     what, want.next_task, want.next_idle, o_next_task, o_next_idle);
        end
    endtask

    always @(posedge i_clk) begin : drive_inputs
        t_item it;
        bit    free;
        logic  nxt_valid;
        if (i_rst_n) begin
            free = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                predict_next_task(offered);
                n_accepted++;
                free = 1'b1;
            end
            nxt_valid = i_in_valid && !free;
            if (free && pending_items.size() > 0
                && !(pending_items[0].drain_first && next_task_expected.size() > 0)
                && $urandom_range(99) >= idle_pct(1'b0)) begin
                it              = pending_items.pop_front();
                offered         = it;
                i_kind         <= it.kind;
                i_task_id      <= it.task_id;
                i_burst        <= it.burst;
                i_reason       <= it.reason;
                i_current_task <= it.current_task;
                i_current_idle <= it.current_idle;
                nxt_valid       = 1'b1;
            end
            i_in_valid <= nxt_valid;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_choice want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (next_task_expected.size() == 0) begin
                    want.next_task = 'x;
                    want.next_idle = 1'bx;
                    flag_mismatch("unexpected transaction", want);
                end else begin
                    want = next_task_expected.pop_front();
                    n_checked++;
                    if (o_next_task !== want.next_task || o_next_idle !== want.next_idle) begin
                        flag_mismatch("mismatch", want);
                    end
                end
            end
            // long receiver hold so the queue fills and input backs up
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_count < 2 && n_accepted >= hold_at[hold_count]) begin
                hold_left = HOLD_CYCLES;
                hold_count++;
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, next_task_expected.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        t_item                 it;
        logic [BURST_BITS-1:0] key;
        logic [1:0]            rsn;
        int                    load_pct;
        int                    seg_left;
        int                    pick;

        // events on an empty queue
        add_item(make_event(RSN_TICK, '0, 1'b1));
        add_item(make_event(RSN_TICK, '1, 1'b0));
        add_item(make_event(RSN_BLOCK, ID_BITS'('hA5), 1'b0));
        add_item(make_event(RSN_BLOCK, ID_BITS'('h5A), 1'b1));
        add_item(make_event(RSN_EXIT, ID_BITS'('h3C), 1'b0));
        add_item(make_event(RSN_RESERVED, ID_BITS'('hC3), 1'b0));
        add_item(make_event(RSN_RESERVED, '0, 1'b1));
        // fill past full with field extremes and equal bursts
        add_item(make_load('0, '0));
        add_item(make_load('1, '1));
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            key = (k % 3 == 0) ? BURST_BITS'('h5555) :
                  (k % 3 == 1) ? BURST_BITS'('hAAAA) : BURST_BITS'(k);
            add_item(make_load(ID_BITS'(16 + k), key));
        end
        add_item(make_event(RSN_EXIT, ID_BITS'('h81), 1'b0));
        add_item(make_event(RSN_TICK, '0, 1'b1));
        add_item(make_event(RSN_TICK, ID_BITS'('h42), 1'b0));
        add_item(make_event(RSN_BLOCK, ID_BITS'('h24), 1'b1));
        add_item(make_event(RSN_RESERVED, ID_BITS'('h99), 1'b0));

        // random segments, each with a fill-heavy, balanced or drain-heavy mix picked at random
        load_pct = 50;
        seg_left = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(2))
                    0: load_pct = 20;
                    1: load_pct = 50;
                    default: load_pct = 85;
                endcase
            end
            seg_left--;
            if ($urandom_range(99) < load_pct) begin
                key = ($urandom_range(3) == 0) ? BURST_BITS'($urandom)
                                               : BURST_BITS'($urandom_range(7));
                it = make_load(ID_BITS'($urandom), key);
            end else begin
                pick = $urandom_range(9);
                rsn  = (pick < 4) ? RSN_EXIT : (pick < 7) ? RSN_TICK :
                       (pick < 9) ? RSN_BLOCK : RSN_RESERVED;
                it   = make_event(rsn, ID_BITS'($urandom), 1'($urandom_range(1)));
            end
            it.drain_first = (n == 0) || (n == N_RANDOM / 2) || ($urandom_range(249) == 0);
            add_item(it);
        end
        n_items_total = pending_items.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || i_in_valid) @(posedge i_clk);
        while (next_task_expected.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d loads (%0d dropped on a full queue) and %0d scheduling events",
                 n_loads, n_dropped, n_events);
        $display("%0d events took the head task, %0d results checked, %0d mismatches",
                 n_popped, n_checked, n_errors);
        if (n_errors == 0 && next_task_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
